### src/assert_macros.svh
// Assertion macros shared by the deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Checks that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/mqtt_pkg.sv
// Package with types, constants and role codes of the MQTT receive deframer.
`default_nettype none
package mqtt_pkg;
    localparam int MAX_LENGTH_BYTES = 3;
    localparam int LEN_W = 21;
    localparam int FIFO_DEPTH = 2;

    typedef enum logic [3:0] {
        PH_HDR, PH_LEN, PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC,
        PH_PID_HI, PH_PID_LO, PH_PAYLOAD, PH_DROP, PH_BODY
    } t_phase;

    localparam logic [2:0] ROLE_HEADER  = 3'd0;
    localparam logic [2:0] ROLE_LENGTH  = 3'd1;
    localparam logic [2:0] ROLE_TLEN    = 3'd2;
    localparam logic [2:0] ROLE_TOPIC   = 3'd3;
    localparam logic [2:0] ROLE_PID     = 3'd4;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd5;
    localparam logic [2:0] ROLE_OTHER   = 3'd6;
    localparam logic [2:0] ROLE_DISCARD = 3'd7;

    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_LEN_OVF      = 3'd1;
    localparam logic [2:0] ST_SHORT_PUB    = 3'd2;
    localparam logic [2:0] ST_CONNACK_OK   = 3'd3;
    localparam logic [2:0] ST_CONNACK_REJ  = 3'd4;
    localparam logic [2:0] ST_SUBACK_OK    = 3'd5;
    localparam logic [2:0] ST_SUBACK_FAIL  = 3'd6;
    localparam logic [2:0] ST_SUBACK_SHORT = 3'd7;

    localparam logic [3:0] TYPE_CONNACK = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;
    localparam logic [3:0] TYPE_SUBACK  = 4'd9;

    typedef struct packed {
        logic [2:0]       byte_role;
        logic [7:0]       data_byte;
        logic [3:0]       packet_type;
        logic [1:0]       qos_level;
        logic             frame_end;
        logic [2:0]       frame_status;
        logic             ack_request;
        logic [15:0]      ack_packet_id;
        logic [7:0]       reply_code;
        logic [7:0]       session_flag;
        logic [LEN_W-1:0] remaining_length;
        logic [7:0]       connect_fail_count;
    } t_result;
endpackage
`default_nettype wire

### src/mqtt_front.sv
// Front part: decodes each byte against the frame state and classifies it.
`default_nettype none
module mqtt_front #(
    parameter int MAX_LENGTH_BYTES = mqtt_pkg::MAX_LENGTH_BYTES
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [7:0]       i_byte,
    output mqtt_pkg::t_result     o_result
);
    localparam int LEN_W = mqtt_pkg::LEN_W;
    localparam int CNT_W = $clog2(MAX_LENGTH_BYTES + 1);

    mqtt_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_hdr, n_hdr;
    logic [LEN_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_lcnt, n_lcnt;
    logic [LEN_W-1:0] r_left, n_left;
    logic [15:0]      r_tleft, n_tleft;
    logic [15:0]      r_pid, n_pid;
    logic [1:0]       r_bidx, n_bidx;
    logic [7:0]       r_code, n_code;
    logic [7:0]       r_sess, n_sess;
    logic [7:0]       r_fail, n_fail;

    logic [3:0]  w_type;
    logic [1:0]  w_qos;
    logic        w_body, w_end;
    logic [LEN_W-1:0] w_shift;
    logic [17:0] w_need;
    logic [15:0] w_tl;
    logic [7:0]  w_rc;
    logic [8:0]  w_sum;
    mqtt_pkg::t_result w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mqtt_pkg::PH_HDR;
            r_hdr   <= '0;
            r_len   <= '0;
            r_lcnt  <= '0;
            r_left  <= '0;
            r_tleft <= '0;
            r_pid   <= '0;
            r_bidx  <= '0;
            r_code  <= 8'hFF;
            r_sess  <= '0;
            r_fail  <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_len   <= n_len;
            r_lcnt  <= n_lcnt;
            r_left  <= n_left;
            r_tleft <= n_tleft;
            r_pid   <= n_pid;
            r_bidx  <= n_bidx;
            r_code  <= n_code;
            r_sess  <= n_sess;
            r_fail  <= n_fail;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_len   = r_len;
        n_lcnt  = r_lcnt;
        n_left  = r_left;
        n_tleft = r_tleft;
        n_pid   = r_pid;
        n_bidx  = r_bidx;
        n_code  = r_code;
        n_sess  = r_sess;
        n_fail  = r_fail;
        w_type  = r_hdr[7:4];
        w_qos   = r_hdr[2:1];
        w_body  = 1'b0;
        w_end   = 1'b0;
        w_shift = '0;
        w_need  = '0;
        w_tl    = '0;
        w_rc    = '0;
        w_sum   = '0;
        w_res   = '0;
        w_res.data_byte = i_byte;

        unique case (r_phase)
            mqtt_pkg::PH_HDR: begin
                n_hdr   = i_byte;
                w_type  = i_byte[7:4];
                w_qos   = i_byte[2:1];
                n_len   = '0;
                n_lcnt  = '0;
                w_res.byte_role = mqtt_pkg::ROLE_HEADER;
                n_phase = mqtt_pkg::PH_LEN;
            end
            mqtt_pkg::PH_LEN: begin
                if (32'(r_lcnt) >= MAX_LENGTH_BYTES) begin
                    w_res.byte_role    = mqtt_pkg::ROLE_DISCARD;
                    w_res.frame_end    = 1'b1;
                    w_res.frame_status = mqtt_pkg::ST_LEN_OVF;
                    n_phase = mqtt_pkg::PH_HDR;
                end else begin
                    w_res.byte_role = mqtt_pkg::ROLE_LENGTH;
                    w_shift = LEN_W'({14'd0, i_byte[6:0]}) << (7 * (32'(r_lcnt) & 3));
                    n_len  = r_len | w_shift;
                    n_lcnt = r_lcnt + 1'b1;
                    if (!i_byte[7]) begin
                        n_left  = n_len;
                        n_bidx  = '0;
                        n_code  = 8'hFF;
                        n_sess  = '0;
                        n_pid   = '0;
                        n_tleft = '0;
                        if (w_type == mqtt_pkg::TYPE_PUBLISH)
                            n_phase = (n_len < LEN_W'(2)) ? mqtt_pkg::PH_DROP
                                                          : mqtt_pkg::PH_TLEN_HI;
                        else
                            n_phase = mqtt_pkg::PH_BODY;
                        if (n_len == '0) w_end = 1'b1;
                    end
                end
            end
            mqtt_pkg::PH_TLEN_HI: begin
                w_res.byte_role = mqtt_pkg::ROLE_TLEN;
                w_body  = 1'b1;
                n_tleft = {i_byte, 8'd0};
                n_phase = mqtt_pkg::PH_TLEN_LO;
            end
            mqtt_pkg::PH_TLEN_LO: begin
                w_res.byte_role = mqtt_pkg::ROLE_TLEN;
                w_body  = 1'b1;
                w_tl    = {r_tleft[15:8], i_byte};
                n_tleft = w_tl;
                w_need  = 18'd2 + 18'(w_tl) + ((w_qos != 2'd0) ? 18'd2 : 18'd0);
                if (LEN_W'(w_need) > r_len)
                    n_phase = mqtt_pkg::PH_DROP;
                else if (w_tl != '0)
                    n_phase = mqtt_pkg::PH_TOPIC;
                else
                    n_phase = (w_qos != 2'd0) ? mqtt_pkg::PH_PID_HI : mqtt_pkg::PH_PAYLOAD;
            end
            mqtt_pkg::PH_TOPIC: begin
                w_res.byte_role = mqtt_pkg::ROLE_TOPIC;
                w_body = 1'b1;
                if (r_tleft != '0) n_tleft = r_tleft - 1'b1;
                if (n_tleft == '0)
                    n_phase = (w_qos != 2'd0) ? mqtt_pkg::PH_PID_HI : mqtt_pkg::PH_PAYLOAD;
            end
            mqtt_pkg::PH_PID_HI: begin
                w_res.byte_role = mqtt_pkg::ROLE_PID;
                w_body  = 1'b1;
                n_pid   = {i_byte, 8'd0};
                n_phase = mqtt_pkg::PH_PID_LO;
            end
            mqtt_pkg::PH_PID_LO: begin
                w_res.byte_role = mqtt_pkg::ROLE_PID;
                w_body  = 1'b1;
                n_pid   = {r_pid[15:8], i_byte};
                n_phase = mqtt_pkg::PH_PAYLOAD;
            end
            mqtt_pkg::PH_PAYLOAD: begin
                w_res.byte_role = mqtt_pkg::ROLE_PAYLOAD;
                w_body = 1'b1;
            end
            mqtt_pkg::PH_DROP: begin
                w_res.byte_role = mqtt_pkg::ROLE_DISCARD;
                w_body = 1'b1;
            end
            default: begin
                w_res.byte_role = mqtt_pkg::ROLE_OTHER;
                w_body = 1'b1;
                if (w_type == mqtt_pkg::TYPE_CONNACK) begin
                    if (r_bidx == 2'd0) n_sess = i_byte;
                    else if (r_bidx == 2'd1) n_code = i_byte;
                end else if (w_type == mqtt_pkg::TYPE_SUBACK && r_bidx == 2'd2) begin
                    n_code = i_byte;
                end
                if (r_bidx != 2'd3) n_bidx = r_bidx + 1'b1;
            end
        endcase

        if (w_body) begin
            if (r_left != '0) n_left = r_left - 1'b1;
            if (n_left == '0) w_end = 1'b1;
        end

        if (w_end) begin
            w_res.frame_end = 1'b1;
            if (w_type == mqtt_pkg::TYPE_CONNACK) begin
                if (n_bidx >= 2'd2) begin
                    w_rc = n_code;
                    w_res.session_flag = n_sess;
                end else begin
                    w_rc = 8'hFF;
                end
                w_res.reply_code = w_rc;
                if (w_rc == 8'd0) begin
                    w_res.frame_status = mqtt_pkg::ST_CONNACK_OK;
                    n_fail = '0;
                end else begin
                    w_res.frame_status = mqtt_pkg::ST_CONNACK_REJ;
                    w_sum = {1'b0, r_fail} +
                            ((w_rc == 8'd4 || w_rc == 8'd5) ? 9'd3 : 9'd1);
                    n_fail = w_sum[8] ? 8'hFF : w_sum[7:0];
                end
            end else if (w_type == mqtt_pkg::TYPE_PUBLISH) begin
                if (n_phase == mqtt_pkg::PH_DROP) begin
                    w_res.frame_status = mqtt_pkg::ST_SHORT_PUB;
                end else if (w_qos == 2'd1) begin
                    w_res.ack_request   = 1'b1;
                    w_res.ack_packet_id = n_pid;
                end
            end else if (w_type == mqtt_pkg::TYPE_SUBACK) begin
                if (n_bidx == 2'd3) begin
                    w_res.reply_code   = n_code;
                    w_res.frame_status = (n_code == 8'h80) ? mqtt_pkg::ST_SUBACK_FAIL
                                                           : mqtt_pkg::ST_SUBACK_OK;
                end else begin
                    w_res.frame_status = mqtt_pkg::ST_SUBACK_SHORT;
                end
            end
            n_phase = mqtt_pkg::PH_HDR;
        end

        w_res.packet_type        = w_type;
        w_res.qos_level          = w_qos;
        w_res.remaining_length   = n_len;
        w_res.connect_fail_count = n_fail;
    end

    assign o_result = w_res;
endmodule
`default_nettype wire

### src/mqtt_queue.sv
// Small result queue between the classifier and the result ports.
`default_nettype none
`include "assert_macros.svh"
module mqtt_queue #(
    parameter int DEPTH = mqtt_pkg::FIFO_DEPTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire mqtt_pkg::t_result  i_data,
    output logic                    o_full,
    input  wire logic               i_pop,
    output logic                    o_empty,
    output mqtt_pkg::t_result       o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    mqtt_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr = i_push && !o_full;
    assign w_rd = i_pop && !o_empty;
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (w_rd) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

    `ASSERT_IMPLIES(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= (AW+1)'(DEPTH))
    `ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_wr && !w_rd, !o_empty)
    `ASSERT_NEXT(a_pop_last, i_clk, i_rst_n, w_rd && !w_wr && r_cnt == (AW+1)'(1), o_empty)
endmodule
`default_nettype wire

### src/mqtt_rx_packet_deframer.sv
// Top level of the MQTT receive deframer: classifier front and result queue.
//  channel | direction | handshake        | payload
//  input   | in        | push / full      | i_rx_byte
//  result  | out       | empty / pop      | o_byte_role .. o_connect_fail_count
// One byte enters per cycle while full is low; its result can be popped in the cycle after the push.
// The classifier updates its registered frame state for each accepted byte.
// Reset clears the frame state and empties the two-entry result queue.
// full rises when the queue holds two untaken results; input stalls then.
`default_nettype none
`include "assert_macros.svh"
module mqtt_rx_packet_deframer #(
    parameter int MAX_LENGTH_BYTES = mqtt_pkg::MAX_LENGTH_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [2:0]       o_byte_role,
    output logic [7:0]       o_data_byte,
    output logic [3:0]       o_packet_type,
    output logic [1:0]       o_qos_level,
    output logic             o_frame_end,
    output logic [2:0]       o_frame_status,
    output logic             o_ack_request,
    output logic [15:0]      o_ack_packet_id,
    output logic [7:0]       o_reply_code,
    output logic [7:0]       o_session_flag,
    output logic [20:0]      o_remaining_length,
    output logic [7:0]       o_connect_fail_count
);
    logic w_accept;
    mqtt_pkg::t_result w_front, w_head;

    assign w_accept = push && !full;

    mqtt_front #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_accept),
        .i_byte(i_rx_byte), .o_result(w_front)
    );

    mqtt_queue #(.DEPTH(mqtt_pkg::FIFO_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_accept), .i_data(w_front),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_data(w_head)
    );

    assign o_byte_role          = w_head.byte_role;
    assign o_data_byte          = w_head.data_byte;
    assign o_packet_type        = w_head.packet_type;
    assign o_qos_level          = w_head.qos_level;
    assign o_frame_end          = w_head.frame_end;
    assign o_frame_status       = w_head.frame_status;
    assign o_ack_request        = w_head.ack_request;
    assign o_ack_packet_id      = w_head.ack_packet_id;
    assign o_reply_code         = w_head.reply_code;
    assign o_session_flag       = w_head.session_flag;
    assign o_remaining_length   = w_head.remaining_length;
    assign o_connect_fail_count = w_head.connect_fail_count;

    `ASSERT_IMPLIES(a_ack_on_end, i_clk, i_rst_n, !empty && o_ack_request, o_frame_end)
    `ASSERT_IMPLIES(a_status_on_end, i_clk, i_rst_n,
        !empty && o_frame_status != mqtt_pkg::ST_OK, o_frame_end)
endmodule
`default_nettype wire
